FILE: hdl/pqsa_pkg.sv
// Package: widths, operation and status codes, and request/result types for the priority queue.
`timescale 1ns / 1ps

package pqsa_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 6;
  localparam int VAL_W  = 32;
  localparam int PRI_W  = 8;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_ADD          = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_OLDEST   = 3'd1;
  localparam logic [OP_W-1:0] OP_ROTATE       = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_PRIORITY = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value_in;
    logic [PRI_W-1:0]        priority_in;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
    logic                    is_full;
  } out_rsp_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        prio;
  } entry_t;

endpackage

FILE: hdl/priority_queue_shift_array_core.sv
// Top level: shifting-array priority queue with one entry memory and a small sequencer.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------
//   request  | in_valid / in_stall | in_req  (pqsa_pkg::in_req_t)
//   result   | out_valid/ out_stall| out_rsp (pqsa_pkg::out_rsp_t)
//
// Add, clear, unknown ops and any op on an empty store go straight to the result state.
// Pop oldest, rotate and pop priority first search the store (only the first entry, or every
// entry for pop priority), then shift the later entries down; one read and one write per cycle.
// Synchronous active-low reset empties the store; memory contents are not cleared.
// A stalled result holds; the next request is taken meanwhile, its result waits behind it.
`timescale 1ns / 1ps

module priority_queue_shift_array_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pqsa_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output pqsa_pkg::out_rsp_t out_rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam int IW = pqsa_pkg::IDX_W;
  localparam int CW = pqsa_pkg::CNT_W;

  pqsa_pkg::entry_t mem [pqsa_pkg::DEPTH];

  logic [1:0]                       state_r, state_nxt;
  logic [pqsa_pkg::OP_W-1:0]        op_r, op_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [CW-1:0]                    lim_r, lim_nxt;
  logic [CW-1:0]                    rd_ptr_r, rd_ptr_nxt;
  logic                             pend_r, pend_nxt;
  logic [IW-1:0]                    idx_r, idx_nxt;
  logic [IW-1:0]                    pos_r, pos_nxt;
  pqsa_pkg::entry_t                 best_r, best_nxt;
  logic signed [pqsa_pkg::VAL_W-1:0] res_val_r, res_val_nxt;
  logic [pqsa_pkg::ST_W-1:0]        res_st_r, res_st_nxt;
  logic                             out_valid_r, out_valid_nxt;
  pqsa_pkg::out_rsp_t               out_rsp_r, out_rsp_nxt;
  pqsa_pkg::entry_t                 rd_data_r;

  logic             we;
  logic [IW-1:0]    wr_addr;
  pqsa_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_ptr_r[IW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    best_nxt      = best_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_rsp_nxt   = out_rsp_r;
    we            = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_req.operation;
          res_val_nxt = '0;
          res_st_nxt  = pqsa_pkg::ST_DONE;
          rd_ptr_nxt  = '0;
          pend_nxt    = 1'b0;
          state_nxt   = S_RESP;
          unique case (in_req.operation) inside
            pqsa_pkg::OP_ADD: begin
              if (cnt_r == CW'(pqsa_pkg::DEPTH)) begin
                res_st_nxt = pqsa_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = cnt_r[IW-1:0];
                wr_data = '{value: in_req.value_in, prio: in_req.priority_in};
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            pqsa_pkg::OP_POP_OLDEST, pqsa_pkg::OP_ROTATE, pqsa_pkg::OP_POP_PRIORITY: begin
              if (cnt_r == '0) begin
                res_st_nxt = pqsa_pkg::ST_EMPTY;
              end else begin
                lim_nxt   = (in_req.operation == pqsa_pkg::OP_POP_PRIORITY) ? cnt_r : CW'(1);
                state_nxt = S_SRCH;
              end
            end
            pqsa_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH: begin
        if (pend_r && (idx_r == '0 || rd_data_r.prio > best_r.prio)) begin
          best_nxt = rd_data_r;
          pos_nxt  = idx_r;
        end
        if (rd_ptr_r < lim_r) begin
          pend_nxt   = 1'b1;
          idx_nxt    = rd_ptr_r[IW-1:0];
          rd_ptr_nxt = rd_ptr_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt   = S_SHIFT;
            rd_ptr_nxt  = CW'(pos_r) + CW'(1);
            res_val_nxt = (op_r == pqsa_pkg::OP_ROTATE) ? '0 : best_r.value;
          end
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          we      = 1'b1;
          wr_addr = idx_r - IW'(1);
          wr_data = rd_data_r;
        end
        if (rd_ptr_r < cnt_r) begin
          pend_nxt   = 1'b1;
          idx_nxt    = rd_ptr_r[IW-1:0];
          rd_ptr_nxt = rd_ptr_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (op_r == pqsa_pkg::OP_ROTATE) begin
              we      = 1'b1;
              wr_addr = IW'(cnt_r - CW'(1));
              wr_data = best_r;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
            end
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.value_out   = res_val_r;
          out_rsp_nxt.status      = res_st_r;
          out_rsp_nxt.entry_count = cnt_r;
          out_rsp_nxt.is_empty    = (cnt_r == '0);
          out_rsp_nxt.is_full     = (cnt_r == CW'(pqsa_pkg::DEPTH));
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    lim_r     <= lim_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    best_r    <= best_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: sim/priority_queue_shift_array_core_tb.sv
// Testbench for the shifting-array priority queue: directed and random requests, predictor, result check.
`timescale 1ns / 1ps

module priority_queue_shift_array_core_tb;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} gen_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pqsa_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pqsa_pkg::out_rsp_t out_rsp;

  pqsa_pkg::in_req_t  req_queue[$];
  pqsa_pkg::out_rsp_t rsp_expected[$];
  pqsa_pkg::entry_t   store_model[$];
  pqsa_pkg::out_rsp_t want_rsp;
  logic     req_taken = 1'b0;
  int       mismatch_count = 0;
  int       gap_left = 0;
  int       burst_left = 0;
  logic [15:0] stall_pattern = '0;
  logic [7:0]  stall_cycle = '0;

  priority_queue_shift_array_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pqsa_pkg::out_rsp_t serve_request(pqsa_pkg::in_req_t r);
    pqsa_pkg::out_rsp_t rsp;
    pqsa_pkg::entry_t   ent;
    int                 best;
    rsp = '0;
    rsp.status = pqsa_pkg::ST_DONE;
    case (r.operation) inside
      pqsa_pkg::OP_ADD: begin
        if (store_model.size() >= pqsa_pkg::DEPTH) begin
          rsp.status = pqsa_pkg::ST_FULL;
        end else begin
          ent.value = r.value_in;
          ent.prio  = r.priority_in;
          store_model.push_back(ent);
        end
      end
      pqsa_pkg::OP_POP_OLDEST, pqsa_pkg::OP_ROTATE, pqsa_pkg::OP_POP_PRIORITY: begin
        if (store_model.size() == 0) begin
          rsp.status = pqsa_pkg::ST_EMPTY;
        end else if (r.operation == pqsa_pkg::OP_POP_OLDEST) begin
          ent = store_model.pop_front();
          rsp.value_out = ent.value;
        end else if (r.operation == pqsa_pkg::OP_ROTATE) begin
          store_model.push_back(store_model.pop_front());
        end else begin
          best = 0;
          for (int i = 1; i < store_model.size(); i++)
            if (store_model[i].prio > store_model[best].prio) best = i;
          rsp.value_out = store_model[best].value;
          store_model.delete(best);
        end
      end
      pqsa_pkg::OP_CLEAR: store_model.delete();
      default: ;
    endcase
    rsp.entry_count = pqsa_pkg::CNT_W'(store_model.size());
    rsp.is_empty    = (store_model.size() == 0);
    rsp.is_full     = (store_model.size() == pqsa_pkg::DEPTH);
    return rsp;
  endfunction

  task automatic add_request(logic [pqsa_pkg::OP_W-1:0] op, logic [pqsa_pkg::VAL_W-1:0] v,
                             logic [pqsa_pkg::PRI_W-1:0] p);
    pqsa_pkg::in_req_t r;
    r.operation   = op;
    r.value_in    = v;
    r.priority_in = p;
    req_queue.push_back(r);
  endtask

  function automatic logic [pqsa_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, pqsa_pkg::out_rsp_t want,
                                 pqsa_pkg::out_rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected value=%0d status=%0d count=%0d empty=%0b full=%0b",
               $time, what, want.value_out, want.status, want.entry_count, want.is_empty,
               want.is_full);
      $display("%0t: %s: got      value=%0d status=%0d count=%0d empty=%0b full=%0b",
               $time, what, got.value_out, got.status, got.entry_count, got.is_empty,
               got.is_full);
    end
  endtask

  // request acceptance and prediction
  always @(posedge clk) begin
    req_taken <= rst_n && in_valid && in_stall === 1'b0;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      rsp_expected.push_back(serve_request(in_req));
      void'(req_queue.pop_front());
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (rsp_expected.size() == 0) begin
        report_mismatch("result with no request pending", '0, out_rsp);
      end else begin
        want_rsp = rsp_expected.pop_front();
        if (out_rsp !== want_rsp) report_mismatch("result mismatch", want_rsp, out_rsp);
      end
    end
  end

  // request driver: bursts with gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_req   <= req_queue[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern, re-picked whenever stall_cycle wraps to zero; bit 0 clear bounds the stall
  always @(negedge clk) begin
    if (stall_cycle == 0) begin
      case ($urandom_range(0, 4)) inside
        [0:1]: stall_pattern = '0;
        2: stall_pattern = 16'($urandom) & 16'hfffe;
        3: stall_pattern = 16'haaaa;
        default: stall_pattern = 16'hff00;
      endcase
    end
    out_stall   <= stall_pattern[stall_cycle[3:0]];
    stall_cycle <= stall_cycle + 8'd1;
  end

  initial begin
    gen_mode_t mode;
    int        phase_len;
    int        roll;
    int        add_pct;
    int        pri_kind;
    logic [pqsa_pkg::OP_W-1:0]  op;
    logic [pqsa_pkg::PRI_W-1:0] pri;

    // directed: extremes, ties, every operation, empty cases, unknown codes
    add_request(pqsa_pkg::OP_POP_OLDEST, 32'h1234_5678, 8'hff);
    add_request(pqsa_pkg::OP_ROTATE, '1, '1);
    add_request(pqsa_pkg::OP_POP_PRIORITY, '0, '0);
    add_request(pqsa_pkg::OP_CLEAR, '0, '0);
    add_request(pqsa_pkg::OP_ADD, 32'h7fff_ffff, 8'hff);
    add_request(pqsa_pkg::OP_ADD, 32'h8000_0000, 8'h00);
    add_request(pqsa_pkg::OP_ADD, 32'hffff_ffff, 8'hff);
    add_request(pqsa_pkg::OP_ADD, 32'h0000_0000, 8'h80);
    add_request(pqsa_pkg::OP_ADD, 32'h5555_aaaa, 8'h01);
    add_request(pqsa_pkg::OP_POP_PRIORITY, '0, '0);
    add_request(pqsa_pkg::OP_ROTATE, '0, '0);
    add_request(pqsa_pkg::OP_POP_OLDEST, '0, '0);
    add_request(pqsa_pkg::OP_POP_PRIORITY, '0, '0);
    add_request(3'd5, 32'hdead_beef, 8'h7f);
    add_request(3'd6, '1, '1);
    add_request(3'd7, '1, '1);
    add_request(pqsa_pkg::OP_POP_PRIORITY, '0, '0);
    add_request(pqsa_pkg::OP_CLEAR, '0, '0);
    add_request(pqsa_pkg::OP_POP_PRIORITY, '0, '0);
    add_request(pqsa_pkg::OP_ADD, 32'h0000_0001, 8'h00);
    add_request(pqsa_pkg::OP_ADD, 32'h0000_0002, 8'h00);
    add_request(pqsa_pkg::OP_POP_PRIORITY, '0, '0);
    add_request(pqsa_pkg::OP_CLEAR, '0, '0);

    while (req_queue.size() < 1310) begin
      mode      = gen_mode_t'($urandom_range(0, 2));
      phase_len = (mode == MODE_FILL) ? $urandom_range(45, 90) : $urandom_range(20, 70);
      pri_kind  = $urandom_range(0, 2);
      add_pct   = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 15 : 45;
      for (int n = 0; n < phase_len; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) op = pqsa_pkg::OP_ADD;
        else if (roll < 96) begin
          case ($urandom_range(0, 3))
            0: op = pqsa_pkg::OP_POP_OLDEST;
            1: op = pqsa_pkg::OP_ROTATE;
            default: op = pqsa_pkg::OP_POP_PRIORITY;
          endcase
        end else if (roll < 98 && mode == MODE_MIX) op = pqsa_pkg::OP_CLEAR;
        else if (roll < 98) op = pqsa_pkg::OP_POP_PRIORITY;
        else op = pqsa_pkg::OP_W'($urandom_range(5, 7));
        case (pri_kind)
          0: pri = pqsa_pkg::PRI_W'($urandom_range(0, 3));
          1: pri = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
          default: pri = pqsa_pkg::PRI_W'($urandom);
        endcase
        add_request(op, pick_value(), pri);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || rsp_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: priority_queue_shift_array_core.f
hdl/pqsa_pkg.sv
hdl/priority_queue_shift_array_core.sv
sim/priority_queue_shift_array_core_tb.sv
